FILE: hdl/umrw_pkg.sv
// shared types, constants and helper function of the reordering window
package umrw_pkg;

  localparam int SN_MAX_BITS   = 10;
  localparam int SN_LONG_BITS  = 10;
  localparam int SN_SHORT_BITS = 5;
  localparam int SN_LONG_EFF   = (SN_LONG_BITS > SN_MAX_BITS) ? SN_MAX_BITS : SN_LONG_BITS;
  localparam int SN_SHORT_EFF  = (SN_SHORT_BITS > SN_MAX_BITS) ? SN_MAX_BITS : SN_SHORT_BITS;
  localparam int WORD_BITS     = 5;
  localparam int WORD_W        = 1 << WORD_BITS;
  localparam int ROW_W         = SN_MAX_BITS - WORD_BITS;
  localparam int ROWS          = 1 << ROW_W;
  localparam int TICK_W        = 12;
  localparam int STATUS_W      = 3;
  localparam int CFG_IDX_W     = 1;

  typedef logic [SN_MAX_BITS-1:0] sn_t;
  typedef logic [SN_MAX_BITS:0]   snc_t;
  typedef logic [ROW_W-1:0]       row_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [WORD_BITS-1:0]   bitpos_t;
  typedef logic [TICK_W-1:0]      tick_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  localparam sn_t MASK_LONG  = sn_t'((1 << SN_LONG_EFF) - 1);
  localparam sn_t MASK_SHORT = sn_t'((1 << SN_SHORT_EFF) - 1);
  localparam tick_t TICKS_RESET = tick_t'(50);

  // register indexes of the configuration port
  localparam cfg_idx_t CFG_SN_LENGTH = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_REORDER   = cfg_idx_t'(1);

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED  = 3'd0,
    STAT_BEHIND  = 3'd1,
    STAT_DUP     = 3'd2,
    STAT_TICK    = 3'd3,
    STAT_EXPIRED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDX,
    S_EVAL,
    S_SRD,
    S_SCHK,
    S_TMR,
    S_CRD,
    S_CWR,
    S_OUT
  } fsm_t;

  // access request towards the bitmap memory
  typedef struct packed {
    logic  rd_en;
    row_t  rd_row;
    logic  wr_en;
    row_t  wr_row;
    word_t wr_data;
  } map_req_t;

  // distance of v above the lower window edge VR(UH) - W
  function automatic sn_t win_off(sn_t v, sn_t uh, sn_t w, sn_t mask);
    sn_t base;
    base = (uh - w) & mask;
    return (v - base) & mask;
  endfunction

endpackage

FILE: hdl/umrw_if.sv
// handshake channel interfaces: input beat, result beat and register write
interface umrw_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [umrw_pkg::SN_MAX_BITS-1:0] seq_num;
  modport source (output valid, mode, seq_num, input ready);
  modport sink   (input valid, mode, seq_num, output ready);
endinterface

interface umrw_out_if;
  logic                             valid;
  logic                             ready;
  logic [umrw_pkg::STATUS_W-1:0]    status;
  logic [umrw_pkg::SN_MAX_BITS-1:0] release_first;
  logic [umrw_pkg::SN_MAX_BITS-1:0] release_count;
  logic [umrw_pkg::SN_MAX_BITS-1:0] receive_edge;
  logic [umrw_pkg::SN_MAX_BITS-1:0] highest_edge;
  logic                             timer_active;
  modport source (output valid, status, release_first, release_count, receive_edge,
                  highest_edge, timer_active, input ready);
  modport sink   (input valid, status, release_first, release_count, receive_edge,
                  highest_edge, timer_active, output ready);
endinterface

interface umrw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [umrw_pkg::CFG_IDX_W-1:0] index;
  logic [umrw_pkg::TICK_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/umrw_map_ram.sv
// received-mark bitmap: one word per row, registered read, per-row valid bits
module umrw_map_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  umrw_pkg::map_req_t  req,
  output umrw_pkg::word_t     rd_data
);

  umrw_pkg::word_t mem [umrw_pkg::ROWS];
  logic [umrw_pkg::ROWS-1:0] row_vld_r;
  umrw_pkg::word_t rd_word_r;
  logic rd_vld_r;

  // word array write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_row];
    end
  end

  // row valid bits, cleared at reset so unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_row] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.rd_row];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

FILE: hdl/um_receive_reordering_window_unit.sv
// receive reordering window: sequencer around the received-mark bitmap memory
// steps to the result beat: plain tick straight to output; number: bitmap read, evaluate,
// then output on discard; stored number and expiry: gap scan and mark clear, each word by
// word over the bitmap, with the timer update between; a held result waits
// throughput: one item at a time, next item taken in the cycle after the result is loaded
// reset: synchronous active low, pointers and timer to zero, bitmap rows marked empty at once
module um_receive_reordering_window_unit (
  input logic         clk,
  input logic         rst_n,
  umrw_in_if.sink     in_ch,
  umrw_out_if.source  out_ch,
  umrw_cfg_if.sink    cfg_ch
);

  umrw_pkg::map_req_t req;
  umrw_pkg::word_t    rdata;

  umrw_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rdata)
  );

  umrw_pkg::fsm_t    state_r, state_nxt;
  logic              sel_r;
  umrw_pkg::tick_t   ticks_r;
  umrw_pkg::sn_t     ur_r, ur_nxt, uh_r, uh_nxt, ux_r, ux_nxt;
  logic              trun_r, trun_nxt;
  umrw_pkg::tick_t   tleft_r, tleft_nxt;
  logic              mode_r, mode_nxt;
  umrw_pkg::sn_t     x_r, x_nxt, old_ur_r, old_ur_nxt;
  umrw_pkg::sn_t     s_r, s_nxt, start_r, start_nxt;
  umrw_pkg::snc_t    n_r, n_nxt;
  umrw_pkg::status_t status_r, status_nxt;
  umrw_pkg::sn_t     c_r, c_nxt, rem_r, rem_nxt, cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  umrw_pkg::status_t o_status_r, o_status_nxt;
  umrw_pkg::sn_t     o_first_r, o_first_nxt, o_cnt_r, o_cnt_nxt;
  umrw_pkg::sn_t     o_ur_r, o_ur_nxt, o_uh_r, o_uh_nxt;
  logic              o_tmr_r, o_tmr_nxt;

  umrw_pkg::sn_t   mask, w;
  umrw_pkg::snc_t  m_full;
  umrw_pkg::sn_t   ur_m, uh_m, ux_m;

  // modulus, mask and window size of the selected number length
  always_comb begin
    mask   = sel_r ? umrw_pkg::MASK_LONG : umrw_pkg::MASK_SHORT;
    m_full = umrw_pkg::snc_t'(mask) + umrw_pkg::snc_t'(1);
    w      = umrw_pkg::sn_t'(m_full >> 1);
    ur_m   = ur_r & mask;
    uh_m   = uh_r & mask;
    ux_m   = ux_r & mask;
  end

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b1;
      ticks_r <= umrw_pkg::TICKS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        umrw_pkg::CFG_SN_LENGTH: sel_r   <= cfg_ch.data[0];
        umrw_pkg::CFG_REORDER:   ticks_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == umrw_pkg::S_IDLE);

  // result beat register
  assign out_ch.valid         = ov_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.release_first = o_first_r;
  assign out_ch.release_count = o_cnt_r;
  assign out_ch.receive_edge  = o_ur_r;
  assign out_ch.highest_edge  = o_uh_r;
  assign out_ch.timer_active  = o_tmr_r;

  // sequencer state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= umrw_pkg::S_IDLE;
      ur_r     <= '0;
      uh_r     <= '0;
      ux_r     <= '0;
      trun_r   <= 1'b0;
      tleft_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ur_r     <= ur_nxt;
      uh_r     <= uh_nxt;
      ux_r     <= ux_nxt;
      trun_r   <= trun_nxt;
      tleft_r  <= tleft_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    x_r        <= x_nxt;
    old_ur_r   <= old_ur_nxt;
    s_r        <= s_nxt;
    start_r    <= start_nxt;
    n_r        <= n_nxt;
    status_r   <= status_nxt;
    c_r        <= c_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    o_status_r <= o_status_nxt;
    o_first_r  <= o_first_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_ur_r     <= o_ur_nxt;
    o_uh_r     <= o_uh_nxt;
    o_tmr_r    <= o_tmr_nxt;
  end

  // next state, memory requests and pointer updates
  always_comb begin
    umrw_pkg::sn_t     xin, ox, our, oux, nuh, nur;
    umrw_pkg::bitpos_t b;
    umrw_pkg::word_t   lowmask, zeros, clrmask;
    logic              found;
    umrw_pkg::bitpos_t pos;
    umrw_pkg::snc_t    avail, len, ii;
    logic              run;

    state_nxt    = state_r;
    ur_nxt       = ur_r;
    uh_nxt       = uh_r;
    ux_nxt       = ux_r;
    trun_nxt     = trun_r;
    tleft_nxt    = tleft_r;
    mode_nxt     = mode_r;
    x_nxt        = x_r;
    old_ur_nxt   = old_ur_r;
    s_nxt        = s_r;
    start_nxt    = start_r;
    n_nxt        = n_r;
    status_nxt   = status_r;
    c_nxt        = c_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    ov_nxt       = ov_r;
    o_status_nxt = o_status_r;
    o_first_nxt  = o_first_r;
    o_cnt_nxt    = o_cnt_r;
    o_ur_nxt     = o_ur_r;
    o_uh_nxt     = o_uh_r;
    o_tmr_nxt    = o_tmr_r;
    req          = '0;

    xin   = in_ch.seq_num & mask;
    ox    = umrw_pkg::win_off(x_r, uh_r, w, mask);
    our   = umrw_pkg::win_off(ur_r, uh_r, w, mask);
    oux   = umrw_pkg::win_off(ux_r, uh_r, w, mask);
    nuh   = (x_r + umrw_pkg::sn_t'(1)) & mask;
    nur   = ur_r;
    run   = trun_r;
    found = 1'b0;
    pos   = '0;
    clrmask = '0;
    avail = '0;
    len   = '0;
    ii    = '0;

    // first clear mark at or above the scan offset
    b       = s_r[umrw_pkg::WORD_BITS-1:0];
    lowmask = ~({umrw_pkg::WORD_W{1'b1}} << b);
    zeros   = ~(rdata | lowmask);
    for (int i = umrw_pkg::WORD_W - 1; i >= 0; i--) begin
      if (zeros[i]) begin
        found = 1'b1;
        pos   = umrw_pkg::bitpos_t'(i);
      end
    end

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      umrw_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt   = in_ch.mode;
          x_nxt      = xin;
          ur_nxt     = ur_m;
          uh_nxt     = uh_m;
          ux_nxt     = ux_m;
          old_ur_nxt = ur_m;
          cnt_nxt    = '0;
          n_nxt      = '0;
          if (!in_ch.mode) begin
            state_nxt = umrw_pkg::S_RDX;
          end else if (!trun_r) begin
            status_nxt = umrw_pkg::STAT_TICK;
            state_nxt  = umrw_pkg::S_OUT;
          end else if (tleft_r > umrw_pkg::tick_t'(1)) begin
            status_nxt = umrw_pkg::STAT_TICK;
            tleft_nxt  = tleft_r - umrw_pkg::tick_t'(1);
            state_nxt  = umrw_pkg::S_OUT;
          end else begin
            status_nxt = umrw_pkg::STAT_EXPIRED;
            if (umrw_pkg::win_off(ux_m, uh_m, w, mask) <
                umrw_pkg::win_off(ur_m, uh_m, w, mask)) begin
              s_nxt     = ur_m;
              start_nxt = ur_m;
            end else begin
              s_nxt     = ux_m;
              start_nxt = ux_m;
            end
            state_nxt = umrw_pkg::S_SRD;
          end
        end
      end
      umrw_pkg::S_RDX: begin
        req.rd_en  = 1'b1;
        req.rd_row = x_r[umrw_pkg::SN_MAX_BITS-1:umrw_pkg::WORD_BITS];
        state_nxt  = umrw_pkg::S_EVAL;
      end
      umrw_pkg::S_EVAL: begin
        if (ox < our) begin
          status_nxt = umrw_pkg::STAT_BEHIND;
          state_nxt  = umrw_pkg::S_OUT;
        end else if (rdata[x_r[umrw_pkg::WORD_BITS-1:0]] && ox > our && ox < w) begin
          status_nxt = umrw_pkg::STAT_DUP;
          state_nxt  = umrw_pkg::S_OUT;
        end else begin
          status_nxt  = umrw_pkg::STAT_STORED;
          req.wr_en   = 1'b1;
          req.wr_row  = x_r[umrw_pkg::SN_MAX_BITS-1:umrw_pkg::WORD_BITS];
          req.wr_data = rdata;
          req.wr_data[x_r[umrw_pkg::WORD_BITS-1:0]] = 1'b1;
          if (ox >= w) begin
            uh_nxt = nuh;
            if (umrw_pkg::win_off(ur_r, nuh, w, mask) >= w) begin
              nur = (nuh - w) & mask;
            end
          end
          ur_nxt    = nur;
          s_nxt     = nur;
          start_nxt = nur;
          state_nxt = umrw_pkg::S_SRD;
        end
      end
      umrw_pkg::S_SRD: begin
        req.rd_en  = 1'b1;
        req.rd_row = s_r[umrw_pkg::SN_MAX_BITS-1:umrw_pkg::WORD_BITS];
        state_nxt  = umrw_pkg::S_SCHK;
      end
      umrw_pkg::S_SCHK: begin
        // gap search, bounded to one full turn of the numbers
        avail = umrw_pkg::snc_t'(umrw_pkg::WORD_W) - umrw_pkg::snc_t'(b);
        if (found) begin
          ur_nxt    = {s_r[umrw_pkg::SN_MAX_BITS-1:umrw_pkg::WORD_BITS], pos} & mask;
          state_nxt = umrw_pkg::S_TMR;
        end else if (n_r + avail >= m_full) begin
          ur_nxt    = start_r;
          state_nxt = umrw_pkg::S_TMR;
        end else begin
          n_nxt     = n_r + avail;
          s_nxt     = ((s_r | umrw_pkg::sn_t'(umrw_pkg::WORD_W - 1)) + umrw_pkg::sn_t'(1))
                      & mask;
          state_nxt = umrw_pkg::S_SRD;
        end
      end
      umrw_pkg::S_TMR: begin
        // timer stop and restart after the edges have moved
        if (!mode_r) begin
          if (run && (oux <= our || (oux >= w && ux_r != uh_r))) begin
            run       = 1'b0;
            tleft_nxt = '0;
          end
          if (!run && our < w) begin
            run       = 1'b1;
            tleft_nxt = ticks_r;
            ux_nxt    = uh_r;
          end
        end else if (our < w) begin
          tleft_nxt = ticks_r;
          ux_nxt    = uh_r;
        end else begin
          run       = 1'b0;
          tleft_nxt = '0;
        end
        trun_nxt = run;
        cnt_nxt  = (ur_r - old_ur_r) & mask;
        rem_nxt  = (ur_r - old_ur_r) & mask;
        c_nxt    = old_ur_r;
        if (((ur_r - old_ur_r) & mask) == '0) begin
          state_nxt = umrw_pkg::S_OUT;
        end else begin
          state_nxt = umrw_pkg::S_CRD;
        end
      end
      umrw_pkg::S_CRD: begin
        req.rd_en  = 1'b1;
        req.rd_row = c_r[umrw_pkg::SN_MAX_BITS-1:umrw_pkg::WORD_BITS];
        state_nxt  = umrw_pkg::S_CWR;
      end
      umrw_pkg::S_CWR: begin
        // clear the released marks of this word
        avail = umrw_pkg::snc_t'(umrw_pkg::WORD_W)
                - umrw_pkg::snc_t'(c_r[umrw_pkg::WORD_BITS-1:0]);
        len   = (umrw_pkg::snc_t'(rem_r) < avail) ? umrw_pkg::snc_t'(rem_r) : avail;
        for (int i = 0; i < umrw_pkg::WORD_W; i++) begin
          ii = umrw_pkg::snc_t'(i);
          clrmask[i] = (ii >= umrw_pkg::snc_t'(c_r[umrw_pkg::WORD_BITS-1:0])) &&
                       (ii < umrw_pkg::snc_t'(c_r[umrw_pkg::WORD_BITS-1:0]) + len);
        end
        req.wr_en   = 1'b1;
        req.wr_row  = c_r[umrw_pkg::SN_MAX_BITS-1:umrw_pkg::WORD_BITS];
        req.wr_data = rdata & ~clrmask;
        rem_nxt     = rem_r - umrw_pkg::sn_t'(len);
        c_nxt       = (c_r + umrw_pkg::sn_t'(len)) & mask;
        if (umrw_pkg::snc_t'(rem_r) == len) begin
          state_nxt = umrw_pkg::S_OUT;
        end else begin
          state_nxt = umrw_pkg::S_CRD;
        end
      end
      umrw_pkg::S_OUT: begin
        if (!ov_r) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_first_nxt  = (cnt_r != '0) ? old_ur_r : '0;
          o_cnt_nxt    = cnt_r;
          o_ur_nxt     = ur_r;
          o_uh_nxt     = uh_r;
          o_tmr_nxt    = trun_r;
          state_nxt    = umrw_pkg::S_IDLE;
        end
      end
      default: state_nxt = umrw_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // a stopped timer carries no count
  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !trun_r |-> tleft_r == '0) else $error("timer count without running timer");

  // never a read and a write of the same bitmap word in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd_en && req.wr_en && req.rd_row == req.wr_row))
    else $error("bitmap read and write collide");

  // a released range ends at the new receive edge
  a_release_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && sel_r && o_cnt_r != '0) |-> o_ur_r == o_first_r + o_cnt_r)
    else $error("released range does not end at receive edge");

  // a new beat is loaded only into an empty result register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == umrw_pkg::S_OUT && ov_r && !out_ch.ready) |=> state_r == umrw_pkg::S_OUT)
    else $error("result beat overwritten");
`endif

endmodule

FILE: tb/um_receive_reordering_window_unit_test.sv
// testbench of the receive reordering window: random and directed beats against a predictor
module um_receive_reordering_window_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_SN   = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_PER_PHASE = 57;

  typedef enum logic [1:0] { K_BEAT, K_REG, K_HOLD } stim_kind_t;
  typedef enum logic [1:0] { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_t;

  typedef struct {
    stim_kind_t          kind;
    logic                mode;
    umrw_pkg::sn_t       sn;
    umrw_pkg::cfg_idx_t  reg_idx;
    umrw_pkg::tick_t     reg_data;
    idle_t               idle;
  } stim_t;

  typedef struct {
    umrw_pkg::status_t status;
    umrw_pkg::sn_t     rel_first;
    umrw_pkg::sn_t     rel_count;
    umrw_pkg::sn_t     recv_edge;
    umrw_pkg::sn_t     high_edge;
    logic              tmr_active;
  } window_result_t;

  logic clk;
  logic rst_n;

  umrw_in_if  in_ch ();
  umrw_out_if out_ch ();
  umrw_cfg_if cfg_ch ();

  um_receive_reordering_window_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock and reset
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  stim_t          pending_q[$];
  window_result_t release_q[$];
  int             fail_count = 0;
  int             quiet_cycles = 0;
  int             settle_count = 0;
  idle_t          idle_now = IDLE_NONE;

  // predictor state
  bit          rx_marks [1024];
  int unsigned sn_long_sel = 1;
  int unsigned ticks_cfg = 50;
  int unsigned vr_recv = 0;
  int unsigned vr_high = 0;
  int unsigned vr_trig = 0;
  bit          tmr_on = 1'b0;
  int unsigned tmr_left = 0;

  // distance above the lower window edge
  function automatic int unsigned edge_dist(int unsigned v, int unsigned uh,
                                            int unsigned w, int unsigned mask);
    return (v - ((uh - w) & mask)) & mask;
  endfunction

  // first unmarked number at or after start, one turn at most
  function automatic int unsigned first_gap(int unsigned start, int unsigned m,
                                            int unsigned mask);
    int unsigned s;
    int unsigned n;
    s = start & mask;
    n = 0;
    while (rx_marks[s] && n < m) begin
      s = (s + 1) & mask;
      n++;
    end
    return s;
  endfunction

  function automatic window_result_t window_step(logic md, umrw_pkg::sn_t sn_in);
    window_result_t r;
    int unsigned m, mask, w, ur, uh, ux, old_ur, x, ox, our, oux, cnt, start;
    umrw_pkg::status_t st;
    m = sn_long_sel ? 1024 : 32;
    mask = m - 1;
    w = m >> 1;
    ur = vr_recv & mask;
    uh = vr_high & mask;
    ux = vr_trig & mask;
    old_ur = ur;
    if (md == MODE_SN) begin
      x = sn_in & mask;
      ox = edge_dist(x, uh, w, mask);
      our = edge_dist(ur, uh, w, mask);
      if (ox < our) begin
        st = umrw_pkg::STAT_BEHIND;
      end else if (rx_marks[x] && ox > our && ox < w) begin
        st = umrw_pkg::STAT_DUP;
      end else begin
        st = umrw_pkg::STAT_STORED;
        rx_marks[x] = 1'b1;
        if (ox >= w) begin
          uh = (x + 1) & mask;
          if (edge_dist(ur, uh, w, mask) >= w) ur = (uh - w) & mask;
        end
        ur = first_gap(ur, m, mask);
        if (tmr_on) begin
          oux = edge_dist(ux, uh, w, mask);
          if (oux <= edge_dist(ur, uh, w, mask) || (oux >= w && ux != uh)) begin
            tmr_on = 1'b0;
            tmr_left = 0;
          end
        end
        if (!tmr_on && edge_dist(ur, uh, w, mask) < w) begin
          tmr_on = 1'b1;
          tmr_left = ticks_cfg;
          ux = uh;
        end
      end
    end else begin
      st = umrw_pkg::STAT_TICK;
      if (tmr_on) begin
        if (tmr_left <= 1) begin
          st = umrw_pkg::STAT_EXPIRED;
          start = ux;
          if (edge_dist(ux, uh, w, mask) < edge_dist(ur, uh, w, mask)) start = ur;
          ur = first_gap(start, m, mask);
          if (edge_dist(ur, uh, w, mask) < w) begin
            tmr_left = ticks_cfg;
            ux = uh;
          end else begin
            tmr_on = 1'b0;
            tmr_left = 0;
          end
        end else begin
          tmr_left--;
        end
      end
    end
    // released range loses its marks
    cnt = (ur - old_ur) & mask;
    for (int unsigned i = 0; i < cnt; i++) rx_marks[(old_ur + i) & mask] = 1'b0;
    vr_recv = ur;
    vr_high = uh;
    vr_trig = ux;
    r.status = st;
    r.rel_first = (cnt != 0) ? umrw_pkg::sn_t'(old_ur) : '0;
    r.rel_count = umrw_pkg::sn_t'(cnt);
    r.recv_edge = umrw_pkg::sn_t'(ur);
    r.high_edge = umrw_pkg::sn_t'(uh);
    r.tmr_active = tmr_on;
    return r;
  endfunction

  // driver: input, register and result-ready sides
  always @(posedge clk) begin
    logic  fire_in;
    logic  fire_cfg;
    logic  nv;
    logic  ncv;
    stim_t e;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= MODE_SN;
      in_ch.seq_num <= '0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.index <= umrw_pkg::CFG_SN_LENGTH;
      cfg_ch.data <= '0;
      out_ch.ready <= 1'b0;
      settle_count <= 0;
    end else begin
      fire_in = in_ch.valid && in_ch.ready;
      fire_cfg = cfg_ch.valid && cfg_ch.ready;
      nv = in_ch.valid && !fire_in;
      ncv = cfg_ch.valid && !fire_cfg;
      if (fire_in || fire_cfg || release_q.size() != 0) settle_count <= 0;
      else settle_count <= settle_count + 1;
      if (!nv && !ncv && pending_q.size() != 0) begin
        e = pending_q[0];
        unique case (e.kind)
          K_BEAT: begin
            idle_now = e.idle;
            if (!((e.idle == IDLE_SEND && $urandom_range(99) < 85) ||
                  (e.idle == IDLE_BOTH && $urandom_range(99) < 24))) begin
              void'(pending_q.pop_front());
              nv = 1'b1;
              in_ch.mode <= e.mode;
              in_ch.seq_num <= e.sn;
            end
          end
          K_REG: begin
            if (!fire_in && release_q.size() == 0 && settle_count >= SETTLE_CYCLES) begin
              void'(pending_q.pop_front());
              ncv = 1'b1;
              cfg_ch.index <= e.reg_idx;
              cfg_ch.data <= e.reg_data;
            end
          end
          default: begin
            if (!fire_in && release_q.size() == 0) void'(pending_q.pop_front());
          end
        endcase
      end
      in_ch.valid <= nv;
      cfg_ch.valid <= ncv;
      unique case (idle_now)
        IDLE_RECV: out_ch.ready <= ($urandom_range(99) >= 85);
        IDLE_BOTH: out_ch.ready <= ($urandom_range(99) >= 24);
        default:   out_ch.ready <= 1'b1;
      endcase
    end
  end

  // monitor: predict on accepted beats, check result beats, watchdog
  always @(posedge clk) begin
    window_result_t exp_r;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == umrw_pkg::CFG_SN_LENGTH) sn_long_sel = cfg_ch.data[0];
        else if (cfg_ch.index == umrw_pkg::CFG_REORDER) ticks_cfg = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) release_q.push_back(window_step(in_ch.mode, in_ch.seq_num));
      if (out_ch.valid && out_ch.ready) begin
        if (release_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          exp_r = release_q.pop_front();
          if (out_ch.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.release_first !== exp_r.rel_first) begin
            $error("release_first expected %0d actual %0d", exp_r.rel_first,
                   out_ch.release_first);
            fail_count++;
          end
          if (out_ch.release_count !== exp_r.rel_count) begin
            $error("release_count expected %0d actual %0d", exp_r.rel_count,
                   out_ch.release_count);
            fail_count++;
          end
          if (out_ch.receive_edge !== exp_r.recv_edge) begin
            $error("receive_edge expected %0d actual %0d", exp_r.recv_edge,
                   out_ch.receive_edge);
            fail_count++;
          end
          if (out_ch.highest_edge !== exp_r.high_edge) begin
            $error("highest_edge expected %0d actual %0d", exp_r.high_edge,
                   out_ch.highest_edge);
            fail_count++;
          end
          if (out_ch.timer_active !== exp_r.tmr_active) begin
            $error("timer_active expected %0d actual %0d", exp_r.tmr_active,
                   out_ch.timer_active);
            fail_count++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("um_receive_reordering_window_unit: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus queue helpers
  task automatic add_beat(logic md, int unsigned sn, idle_t idl);
    stim_t e;
    e.kind = K_BEAT;
    e.mode = md;
    e.sn = umrw_pkg::sn_t'(sn);
    e.reg_idx = umrw_pkg::CFG_SN_LENGTH;
    e.reg_data = '0;
    e.idle = idl;
    pending_q.push_back(e);
  endtask

  task automatic add_reg(umrw_pkg::cfg_idx_t idx, int unsigned val);
    stim_t e;
    e.kind = K_REG;
    e.mode = MODE_SN;
    e.sn = '0;
    e.reg_idx = idx;
    e.reg_data = umrw_pkg::tick_t'(val);
    e.idle = IDLE_NONE;
    pending_q.push_back(e);
  endtask

  int unsigned phase_len_sel[7] = '{1, 1, 0, 1, 0, 1, 0};
  int unsigned phase_ticks[7]   = '{50, 3, 2, 4095, 0, 1, 4095};

  initial begin
    stim_t hold_e;
    int unsigned cursor;
    int unsigned mask;
    int unsigned pick;
    idle_t idl;
    hold_e.kind = K_HOLD;
    hold_e.mode = MODE_SN;
    hold_e.sn = '0;
    hold_e.reg_idx = umrw_pkg::CFG_SN_LENGTH;
    hold_e.reg_data = '0;
    hold_e.idle = IDLE_NONE;
    // directed: duplicates, behind window, jumps, expiry and tick while stopped
    add_reg(umrw_pkg::CFG_REORDER, 3);
    add_beat(MODE_TICK, 0, IDLE_NONE);
    add_beat(MODE_SN, 0, IDLE_NONE);
    add_beat(MODE_SN, 0, IDLE_NONE);
    add_beat(MODE_SN, 2, IDLE_NONE);
    add_beat(MODE_SN, 2, IDLE_NONE);
    add_beat(MODE_SN, 4, IDLE_NONE);
    add_beat(MODE_SN, 1023, IDLE_NONE);
    add_beat(MODE_SN, 600, IDLE_NONE);
    add_beat(MODE_SN, 511, IDLE_NONE);
    add_beat(MODE_SN, 512, IDLE_NONE);
    for (int i = 0; i < 5; i++) add_beat(MODE_TICK, 1023, IDLE_NONE);
    add_beat(MODE_SN, 1, IDLE_NONE);
    add_beat(MODE_SN, 3, IDLE_NONE);
    for (int i = 0; i < 4; i++) add_beat(MODE_TICK, 0, IDLE_NONE);
    pending_q.push_back(hold_e);
    // random phases over several register settings
    cursor = 600;
    for (int p = 0; p < 7; p++) begin
      add_reg(umrw_pkg::CFG_SN_LENGTH, phase_len_sel[p]);
      add_reg(umrw_pkg::CFG_REORDER, phase_ticks[p]);
      mask = phase_len_sel[p] ? 1023 : 31;
      idl = idle_t'(p % 4);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          add_beat(MODE_TICK, $urandom_range(1023), idl);
        end else if (pick < 33) begin
          add_beat(MODE_SN, $urandom_range(1023), idl);
        end else begin
          // mostly in-window numbers slightly out of order around the front
          cursor = (cursor + $urandom_range(2)) & 1023;
          add_beat(MODE_SN, ((cursor + $urandom_range(6) - 3) & mask) |
                   (($urandom_range(1023)) & ~mask), idl);
        end
        if (p == 3 && i == RANDOM_PER_PHASE / 2) pending_q.push_back(hold_e);
      end
    end
    @(posedge rst_n);
    while (pending_q.size() != 0 || in_ch.valid || cfg_ch.valid || release_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && release_q.size() == 0) begin
      $display("um_receive_reordering_window_unit: match");
    end else begin
      $display("um_receive_reordering_window_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/umrw_pkg.sv
hdl/umrw_if.sv
hdl/umrw_map_ram.sv
hdl/um_receive_reordering_window_unit.sv
tb/um_receive_reordering_window_unit_test.sv
